// ===== rtl/core/vlrf_pkg.sv =====
// Shared constants, codes and interface types of the legacy virtio register file.
`default_nettype none
package vlrf_pkg;

  localparam int MAX_QUEUES = 8;
  localparam int QIDX_W     = $clog2(MAX_QUEUES);
  localparam int ADDR_W     = 48;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PFN_W      = 32;
  localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;
  localparam int QSIZE_W    = 16;

  localparam logic [15:0] CFG_BASE = 16'd20;

  // Register offsets inside the common window.
  localparam logic [15:0] OFS_DEV_FEAT  = 16'd0;
  localparam logic [15:0] OFS_DRV_FEAT  = 16'd4;
  localparam logic [15:0] OFS_QUEUE_PFN = 16'd8;
  localparam logic [15:0] OFS_QUEUE_NUM = 16'd12;
  localparam logic [15:0] OFS_QUEUE_SEL = 16'd14;
  localparam logic [15:0] OFS_NOTIFY    = 16'd16;
  localparam logic [15:0] OFS_STATUS    = 16'd18;
  localparam logic [15:0] OFS_ISR       = 16'd19;

  // Configuration register indexes.
  localparam logic CFG_DEV_FEATURES = 1'b0;
  localparam logic CFG_QUEUE_COUNT  = 1'b1;

  typedef enum logic [2:0] {
    RC_OK    = 3'd0,
    RC_NOSUP = 3'd1,
    RC_SIZE  = 3'd2,
    RC_INVAL = 3'd3,
    RC_FWD   = 3'd4
  } rc_t;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RAISE = 2'd2
  } cmd_t;

  // Updates requested of the per-queue storage by one transaction.
  typedef struct packed {
    logic              sel_wr;
    logic [QIDX_W-1:0] sel_idx;
    logic              size_wr;
    logic [QSIZE_W-1:0] size_val;
    logic              pfn_wr;
    logic [PFN_W-1:0]  pfn_val;
  } ring_ctrl_t;

  // Ring layout of one queue.
  typedef struct packed {
    logic [QSIZE_W-1:0] size;
    logic [ADDR_W-1:0]  desc;
    logic [ADDR_W-1:0]  avail;
    logic [ADDR_W-1:0]  used;
  } ring_view_t;

endpackage
`default_nettype wire

// ===== rtl/core/virtio_legacy_register_file.sv =====
// A transaction taken into the input register has its result loaded into the result
// register, which drives the outputs that the receiver takes.
// Throughput: one transaction per cycle; busy never rises, as each result register
// load also commits the state the next transaction reads.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Synchronous active-low reset clears all status, ISR, queue selection and ring state.
`default_nettype none
module virtio_legacy_register_file
  import vlrf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_command,
  input  wire logic [2:0]          in_bar_index,
  input  wire logic [15:0]         in_port_offset,
  input  wire logic [2:0]          in_access_bytes,
  input  wire logic [31:0]         in_write_data,
  output logic                     out_valid,
  output logic [2:0]               out_result_code,
  output logic [31:0]              out_read_data,
  output logic [2:0]               out_read_bytes,
  output logic                     out_notify_valid,
  output logic [2:0]               out_notify_queue,
  output logic                     out_forward_valid,
  output logic [15:0]              out_forward_offset,
  output logic                     out_irq_pending,
  output logic [ADDR_W-1:0]        out_desc_addr,
  output logic [ADDR_W-1:0]        out_avail_addr,
  output logic [ADDR_W-1:0]        out_used_addr,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [31:0]         cfg_wdata
);

  // Configuration.
  logic [31:0] dev_feat_r;
  logic [3:0]  qcount_r;
  logic [3:0]  live_count;

  // Input register.
  logic        in_vld_r;
  logic [1:0]  cmd_r;
  logic [2:0]  bar_r;
  logic [15:0] port_r;
  logic [2:0]  size_r;
  logic [31:0] data_r;

  // Scalar device state.
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  isr_r, isr_nxt;

  // Transaction results.
  rc_t         rc;
  logic [31:0] rdata;
  logic [2:0]  rbytes;
  logic        nv;
  logic [2:0]  nq;
  logic        fv;
  logic [15:0] fo;

  logic        q_ok;
  logic        q_ok_after;
  logic [15:0] d16;
  logic        d16_ok;

  ring_ctrl_t  ring_ctrl;
  ring_view_t  cur_view;
  ring_view_t  nxt_view;

  // Result register.
  logic              out_valid_r;
  logic [2:0]        rc_r;
  logic [31:0]       rdata_r;
  logic [2:0]        rbytes_r;
  logic              nv_r;
  logic [2:0]        nq_r;
  logic              fv_r;
  logic [15:0]       fo_r;
  logic              irq_r;
  logic [ADDR_W-1:0] desc_r, avail_r, used_r;

  logic [QIDX_W-1:0] sel_r;
  logic [QIDX_W-1:0] sel_nxt;

  assign busy = 1'b0;

  assign live_count = (qcount_r > 4'(MAX_QUEUES)) ? 4'(MAX_QUEUES) : qcount_r;
  assign d16        = data_r[15:0];
  assign d16_ok     = d16 < {12'b0, live_count};
  assign q_ok       = {1'b0, sel_r} < live_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_feat_r <= '0;
      qcount_r   <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEV_FEATURES: dev_feat_r <= cfg_wdata;
        CFG_QUEUE_COUNT:  qcount_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
    if (start && !busy) begin
      cmd_r  <= in_command;
      bar_r  <= in_bar_index;
      port_r <= in_port_offset;
      size_r <= in_access_bytes;
      data_r <= in_write_data;
    end
  end

  always_comb begin
    rc         = RC_NOSUP;
    rdata      = '0;
    rbytes     = '0;
    nv         = 1'b0;
    nq         = '0;
    fv         = 1'b0;
    fo         = '0;
    status_nxt = status_r;
    isr_nxt    = isr_r;
    sel_nxt    = sel_r;
    ring_ctrl  = '0;
    ring_ctrl.sel_idx  = d16[QIDX_W-1:0];
    ring_ctrl.size_val = d16;
    ring_ctrl.pfn_val  = data_r;

    case (cmd_t'(cmd_r))
      CMD_RAISE: begin
        isr_nxt = isr_r | data_r[7:0];
        rc      = RC_OK;
      end
      CMD_READ, CMD_WRITE: begin
        if (bar_r == 3'd0) begin
          if (port_r >= CFG_BASE) begin
            rc = RC_FWD;
            fv = 1'b1;
            fo = port_r - CFG_BASE;
          end else if (cmd_t'(cmd_r) == CMD_READ) begin
            case (port_r)
              OFS_DEV_FEAT: begin
                rc     = RC_OK;
                rdata  = dev_feat_r;
                rbytes = 3'd4;
              end
              OFS_QUEUE_PFN: begin
                if (q_ok) begin
                  rc     = RC_OK;
                  rdata  = cur_view.desc[PAGE_SHIFT +: 32];
                  rbytes = 3'd4;
                end
              end
              OFS_QUEUE_NUM: begin
                if (q_ok) begin
                  rc     = RC_OK;
                  rdata  = {16'b0, cur_view.size};
                  rbytes = 3'd2;
                end
              end
              OFS_STATUS: begin
                rc     = RC_OK;
                rdata  = {24'b0, status_r};
                rbytes = 3'd1;
              end
              OFS_ISR: begin
                rc      = RC_OK;
                rdata   = {24'b0, isr_r};
                rbytes  = 3'd1;
                isr_nxt = '0;
              end
              default: ;
            endcase
          end else begin
            case (port_r)
              OFS_DRV_FEAT: begin
                if (size_r != 3'd4) rc = RC_SIZE;
                else rc = (data_r == dev_feat_r) ? RC_OK : RC_INVAL;
              end
              OFS_QUEUE_PFN: begin
                if (size_r != 3'd4) begin
                  rc = RC_SIZE;
                end else if (q_ok) begin
                  ring_ctrl.pfn_wr = 1'b1;
                  rc = RC_OK;
                end
              end
              OFS_QUEUE_NUM: begin
                if (size_r != 3'd2) begin
                  rc = RC_SIZE;
                end else if (q_ok) begin
                  ring_ctrl.size_wr = 1'b1;
                  rc = RC_OK;
                end
              end
              OFS_QUEUE_SEL: begin
                if (size_r != 3'd2) begin
                  rc = RC_SIZE;
                end else if (d16_ok) begin
                  ring_ctrl.sel_wr = 1'b1;
                  sel_nxt = d16[QIDX_W-1:0];
                  rc = RC_OK;
                end
              end
              OFS_NOTIFY: begin
                if (size_r != 3'd2) begin
                  rc = RC_SIZE;
                end else if (d16_ok) begin
                  nv = 1'b1;
                  nq = d16[2:0];
                  rc = RC_OK;
                end
              end
              OFS_STATUS: begin
                if (size_r != 3'd1) begin
                  rc = RC_SIZE;
                end else begin
                  status_nxt = data_r[7:0];
                  rc = RC_OK;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  assign q_ok_after = {1'b0, sel_nxt} < live_count;

  vlrf_ring_table u_ring_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_en   (in_vld_r),
    .ctrl     (ring_ctrl),
    .cur_view (cur_view),
    .nxt_view (nxt_view)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= '0;
      isr_r       <= '0;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_vld_r;
      if (in_vld_r) begin
        status_r <= status_nxt;
        isr_r    <= isr_nxt;
        sel_r    <= sel_nxt;
      end
    end
    if (in_vld_r) begin
      rc_r     <= rc;
      rdata_r  <= rdata;
      rbytes_r <= rbytes;
      nv_r     <= nv;
      nq_r     <= nq;
      fv_r     <= fv;
      fo_r     <= fo;
      irq_r    <= isr_nxt != 8'd0;
      desc_r   <= q_ok_after ? nxt_view.desc  : '0;
      avail_r  <= q_ok_after ? nxt_view.avail : '0;
      used_r   <= q_ok_after ? nxt_view.used  : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_code    = rc_r;
  assign out_read_data      = rdata_r;
  assign out_read_bytes     = rbytes_r;
  assign out_notify_valid   = nv_r;
  assign out_notify_queue   = nq_r;
  assign out_forward_valid  = fv_r;
  assign out_forward_offset = fo_r;
  assign out_irq_pending    = irq_r;
  assign out_desc_addr      = desc_r;
  assign out_avail_addr     = avail_r;
  assign out_used_addr      = used_r;

endmodule
`default_nettype wire

// ===== rtl/core/vlrf_ring_table.sv =====
// Per-queue ring storage with a shadow copy of the selected queue and PFN layout math.
`default_nettype none
module vlrf_ring_table
  import vlrf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       upd_en,
  input  wire ring_ctrl_t ctrl,
  output ring_view_t      cur_view,
  output ring_view_t      nxt_view
);

  ring_view_t ring_r [MAX_QUEUES];
  ring_view_t cur_r;
  ring_view_t cur_nxt;
  ring_view_t pfn_layout;

  logic [QIDX_W-1:0]     sel_r;
  logic [QIDX_W-1:0]     sel_nxt;
  logic [20:0]           ring_bytes;
  logic [20:0]           ring_round;
  logic [PAGE_NUM_W-1:0] used_page;

  // The rings start on the PFN page; the used ring begins on the first page
  // boundary after 16*size descriptor bytes plus the 6+2*size avail ring.
  always_comb begin
    ring_bytes = {1'b0, cur_r.size, 4'b0} + {4'b0, cur_r.size, 1'b0} + 21'd6;
    ring_round = ring_bytes + 21'(PAGE_BYTES - 1);
    used_page  = PAGE_NUM_W'(ctrl.pfn_val) + PAGE_NUM_W'(ring_round[20:PAGE_SHIFT]);
    pfn_layout.size  = cur_r.size;
    pfn_layout.desc  = {PAGE_NUM_W'(ctrl.pfn_val), {PAGE_SHIFT{1'b0}}};
    pfn_layout.avail = pfn_layout.desc + ADDR_W'({cur_r.size, 4'b0});
    pfn_layout.used  = {used_page, {PAGE_SHIFT{1'b0}}};
  end

  always_comb begin
    cur_nxt = cur_r;
    sel_nxt = sel_r;
    if (upd_en) begin
      if (ctrl.sel_wr) begin
        sel_nxt = ctrl.sel_idx;
        cur_nxt = ring_r[ctrl.sel_idx];
      end else if (ctrl.size_wr) begin
        cur_nxt.size = ctrl.size_val;
      end else if (ctrl.pfn_wr) begin
        cur_nxt = pfn_layout;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= '0;
      cur_r <= '0;
      for (int i = 0; i < MAX_QUEUES; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      sel_r <= sel_nxt;
      cur_r <= cur_nxt;
      if (upd_en && (ctrl.size_wr || ctrl.pfn_wr)) begin
        ring_r[sel_r] <= cur_nxt;
      end
    end
  end

  assign cur_view = cur_r;
  assign nxt_view = cur_nxt;

endmodule
`default_nettype wire
